[rtl/core/bdq_pkg.sv]
// shared constants and codes for the bounded double-ended queue
`default_nettype none
package bdq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 32;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  function automatic addr_t ring_next(addr_t i);
    return (i == ADDR_W'(DEPTH - 1)) ? '0 : i + ADDR_W'(1);
  endfunction

  function automatic addr_t ring_prev(addr_t i);
    return (i == '0) ? ADDR_W'(DEPTH - 1) : i - ADDR_W'(1);
  endfunction

endpackage
`default_nettype wire

[rtl/core/bdq_ram.sv]
// generic single-write single-read ram with registered read data
`default_nettype none
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/bounded_double_ended_queue.sv]
// top level of the bounded double-ended queue
`default_nettype none
// A ring of DEPTH words in a one-port-write, one-port-read ram, with the front and back
// words mirrored in registers. Each request names one operation and returns one result
// carrying status, front and back words, count and empty flag. Pushes, queries and
// refused requests go straight to the output register; a pop that leaves the queue
// non-empty holds its result until the new front or back word has been read from
// the ram's registered read port. A new request is taken while the previous result
// waits in the output register, as long as that result is taken in the same cycle.
module bounded_double_ended_queue (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [bdq_pkg::OP_W-1:0]       in_op,
  input  wire logic [bdq_pkg::VALUE_W-1:0]    in_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [bdq_pkg::STATUS_W-1:0]   out_status,
  output logic      [bdq_pkg::VALUE_W-1:0]    out_front_value,
  output logic      [bdq_pkg::VALUE_W-1:0]    out_back_value,
  output logic      [bdq_pkg::CNT_W-1:0]      out_count,
  output logic                                out_is_empty
);
  import bdq_pkg::*;

  addr_t                head_r, head_nxt;
  addr_t                tail_r, tail_nxt;
  cnt_t                 count_r, count_nxt;
  data_t                front_r, front_nxt;
  data_t                back_r, back_nxt;
  logic                 pend_r, pend_nxt;
  logic                 pend_front_r, pend_front_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;

  logic  acc, full, empty;
  logic  we, re;
  addr_t waddr, raddr;
  data_t wval, rd_data;

  bdq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wval),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign in_ready = !pend_r && (!out_valid_r || out_ready);
  assign acc      = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign wval     = DATA_WIDTH'(in_value);

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    pend_nxt       = pend_r;
    pend_front_nxt = pend_front_r;
    out_valid_nxt  = out_valid_r;
    status_nxt     = status_r;
    we             = 1'b0;
    re             = 1'b0;
    waddr          = ring_prev(head_r);
    raddr          = ring_next(head_r);
    if (acc) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_DONE;
      unique case (in_op)
        OP_PUSH_FRONT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            we        = 1'b1;
            waddr     = ring_prev(head_r);
            head_nxt  = ring_prev(head_r);
            count_nxt = count_r + CNT_W'(1);
            front_nxt = wval;
            if (empty) begin
              back_nxt = wval;
            end
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            we        = 1'b1;
            waddr     = ring_next(tail_r);
            tail_nxt  = ring_next(tail_r);
            count_nxt = count_r + CNT_W'(1);
            back_nxt  = wval;
            if (empty) begin
              front_nxt = wval;
            end
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            head_nxt  = ring_next(head_r);
            count_nxt = count_r - CNT_W'(1);
            if (count_r == CNT_W'(1)) begin
              front_nxt = '0;
              back_nxt  = '0;
            end else begin
              re             = 1'b1;
              raddr          = ring_next(head_r);
              pend_nxt       = 1'b1;
              pend_front_nxt = 1'b1;
              out_valid_nxt  = 1'b0;
            end
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            tail_nxt  = ring_prev(tail_r);
            count_nxt = count_r - CNT_W'(1);
            if (count_r == CNT_W'(1)) begin
              front_nxt = '0;
              back_nxt  = '0;
            end else begin
              re             = 1'b1;
              raddr          = ring_prev(tail_r);
              pend_nxt       = 1'b1;
              pend_front_nxt = 1'b0;
              out_valid_nxt  = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (pend_r) begin
      pend_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      if (pend_front_r) begin
        front_nxt = rd_data;
      end else begin
        back_nxt = rd_data;
      end
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= ADDR_W'(DEPTH - 1);
      count_r     <= '0;
      front_r     <= '0;
      back_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_front_r <= pend_front_nxt;
    status_r     <= status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_front_value = VALUE_W'(front_r);
  assign out_back_value  = VALUE_W'(back_r);
  assign out_count       = count_r;
  assign out_is_empty    = empty;

  a_pend_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !out_valid_r && !in_ready)
    else $error("result shown while ram read pending");

  a_pend_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> out_valid_r && !pend_r)
    else $error("pending pop did not complete");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count beyond depth");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> front_r == '0 && back_r == '0)
    else $error("empty queue with nonzero front or back");

endmodule
`default_nettype wire

[tb/sv/bounded_double_ended_queue_tb.sv]
// self-checking testbench for the bounded double-ended queue with a built-in ring predictor
`timescale 1ns / 1ps

module bounded_double_ended_queue_tb;
  import bdq_pkg::*;

  localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  localparam int RANDOM_PER_PHASE = 104;
  localparam int SETTLE_CYCLES    = 8;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  front;
    logic [VALUE_W-1:0]  back;
    cnt_t                count;
    logic                empty;
  } deque_result_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    int unsigned        reps;
    bit                 typed;
    deque_result_t      result;
  } stim_row_t;

  typedef enum logic [1:0] {TREND_FILL, TREND_DRAIN, TREND_MIXED} trend_t;

  localparam int N_ROWS = 23;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     in_op;
  logic [VALUE_W-1:0]  in_value;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0]  out_front_value;
  logic [VALUE_W-1:0]  out_back_value;
  logic [CNT_W-1:0]    out_count;
  logic                out_is_empty;

  data_t ring_mem [DEPTH];
  int    front_idx;
  int    fill;

  deque_result_t expected_results [$];
  int            send_idle_pct;
  int            recv_stall_pct;
  int            requests_sent;
  int            results_checked;
  int            full_refusals;
  int            empty_refusals;
  int            mismatches;

  stim_row_t directed_rows [N_ROWS] = '{
    '{OP_QUERY,      32'h0000_0000, 1,  1'b1, '{ST_DONE,  32'h0, 32'h0, 7'd0, 1'b1}},
    '{OP_POP_FRONT,  32'hFFFF_FFFF, 1,  1'b1, '{ST_EMPTY, 32'h0, 32'h0, 7'd0, 1'b1}},
    '{OP_POP_BACK,   32'h0000_0000, 1,  1'b1, '{ST_EMPTY, 32'h0, 32'h0, 7'd0, 1'b1}},
    '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1,  1'b1,
      '{ST_DONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd1, 1'b0}},
    '{OP_PUSH_BACK,  32'h0000_0000, 1,  1'b1,
      '{ST_DONE, 32'hFFFF_FFFF, 32'h0000_0000, 7'd2, 1'b0}},
    '{OP_PUSH_FRONT, 32'h0000_0001, 1,  1'b0, '0},
    '{OP_PUSH_BACK,  32'h8000_0000, 1,  1'b0, '0},
    '{OP_SPARE_A,    32'hA5A5_A5A5, 1,  1'b0, '0},
    '{OP_SPARE_B,    32'h5A5A_5A5A, 1,  1'b0, '0},
    '{OP_SPARE_C,    32'hFFFF_FFFF, 1,  1'b0, '0},
    '{OP_POP_BACK,   32'h0000_0000, 1,  1'b0, '0},
    '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b0, '0},
    '{OP_POP_BACK,   32'h0000_0000, 1,  1'b0, '0},
    '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b1, '{ST_DONE,  32'h0, 32'h0, 7'd0, 1'b1}},
    '{OP_POP_BACK,   32'h0000_0000, 1,  1'b1, '{ST_EMPTY, 32'h0, 32'h0, 7'd0, 1'b1}},
    '{OP_PUSH_FRONT, 32'h8000_0001, 1,  1'b1,
      '{ST_DONE, 32'h8000_0001, 32'h8000_0001, 7'd1, 1'b0}},
    '{OP_PUSH_BACK,  32'hDEAD_BEEF, 63, 1'b0, '0},
    '{OP_PUSH_BACK,  32'h1234_5678, 1,  1'b1,
      '{ST_FULL, 32'h8000_0001, 32'hDEAD_BEEF, 7'd64, 1'b0}},
    '{OP_PUSH_FRONT, 32'h0000_0000, 1,  1'b1,
      '{ST_FULL, 32'h8000_0001, 32'hDEAD_BEEF, 7'd64, 1'b0}},
    '{OP_QUERY,      32'h0000_0000, 1,  1'b1,
      '{ST_DONE, 32'h8000_0001, 32'hDEAD_BEEF, 7'd64, 1'b0}},
    '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b0, '0},
    '{OP_PUSH_FRONT, 32'h7FFF_FFFF, 1,  1'b0, '0},
    '{OP_PUSH_BACK,  32'h0000_0000, 1,  1'b1,
      '{ST_FULL, 32'h7FFF_FFFF, 32'hDEAD_BEEF, 7'd64, 1'b0}}
  };

  bounded_double_ended_queue dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_count       (out_count),
    .out_is_empty    (out_is_empty)
  );

  function automatic deque_result_t apply_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
    deque_result_t res;
    res = '0;
    res.status = ST_DONE;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          res.status = ST_FULL;
          full_refusals++;
        end else if (op == OP_PUSH_FRONT) begin
          front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
          ring_mem[front_idx] = data_t'(value);
          fill++;
        end else begin
          ring_mem[(front_idx + fill) % DEPTH] = data_t'(value);
          fill++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
          empty_refusals++;
        end else begin
          if (op == OP_POP_FRONT) begin
            front_idx = (front_idx + 1) % DEPTH;
          end
          fill--;
        end
      end
      default: ;
    endcase
    if (fill != 0) begin
      res.front = ring_mem[front_idx];
      res.back  = ring_mem[(front_idx + fill - 1) % DEPTH];
    end
    res.count = cnt_t'(fill);
    res.empty = (fill == 0);
    return res;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(trend_t trend);
    int roll;
    int push_pct;
    int pop_pct;
    roll = $urandom_range(99);
    case (trend)
      TREND_FILL:  begin push_pct = 70; pop_pct = 20; end
      TREND_DRAIN: begin push_pct = 20; pop_pct = 70; end
      default:     begin push_pct = 45; pop_pct = 45; end
    endcase
    if (roll < push_pct) begin
      return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    end
    if (roll < push_pct + pop_pct) begin
      return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
    end
    case ($urandom_range(3))
      0: return OP_QUERY;
      1: return OP_SPARE_A;
      2: return OP_SPARE_B;
      default: return OP_SPARE_C;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return VALUE_W'(1) << $urandom_range(VALUE_W - 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                              input bit typed, input deque_result_t typed_result);
    deque_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_op    = op;
    in_value = value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_request(op, value);
    expected_results.insert(expected_results.size(), typed ? typed_result : predicted);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic drain_pending();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    deque_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending: status %0d count %0d", out_status, out_count);
        mismatches++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        results_checked++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_front_value !== want.front) begin
          $error("front_value: expected %h, got %h", want.front, out_front_value);
          mismatches++;
        end
        if (out_back_value !== want.back) begin
          $error("back_value: expected %h, got %h", want.back, out_back_value);
          mismatches++;
        end
        if (out_count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_count);
          mismatches++;
        end
        if (out_is_empty !== want.empty) begin
          $error("is_empty: expected %0d, got %0d", want.empty, out_is_empty);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("bounded_double_ended_queue_tb: done, errors");
    $finish;
  end

  initial begin
    trend_t trend;
    int     trend_left;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = OP_QUERY;
    in_value        = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    requests_sent   = 0;
    results_checked = 0;
    full_refusals   = 0;
    empty_refusals  = 0;
    mismatches      = 0;
    front_idx       = 0;
    fill            = 0;
    trend           = TREND_FILL;
    trend_left      = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    for (int r = 0; r < N_ROWS; r++) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_request(directed_rows[r].op, directed_rows[r].value,
                     directed_rows[r].typed, directed_rows[r].result);
      end
    end
    drain_pending();

    // random traffic under four flow-control profiles
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (trend_left == 0) begin
          trend      = trend_t'($urandom_range(2));
          trend_left = $urandom_range(20, 80);
        end
        trend_left--;
        send_request(pick_op(trend), pick_value(), 1'b0, '0);
      end
      // hold off until every request has come back
      drain_pending();
    end

    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests, %0d results checked", requests_sent, results_checked);
    $display("refused: %0d pushes on a full queue, %0d pops on an empty queue",
             full_refusals, empty_refusals);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("bounded_double_ended_queue_tb: done, clean");
    end else begin
      $display("bounded_double_ended_queue_tb: done, errors");
    end
    $finish;
  end

endmodule

[bounded_double_ended_queue.f]
rtl/core/bdq_pkg.sv
rtl/core/bdq_ram.sv
rtl/core/bounded_double_ended_queue.sv
tb/sv/bounded_double_ended_queue_tb.sv
